>>> src/q3gemv_pkg.sv
// Shared types and constants for the 3-bit weight, 8-bit activation eight-row GEMV unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package q3gemv_pkg;

	localparam int ROWS        = 8;
	localparam int PAIRS       = 4;
	localparam int ACT_W       = 8;
	localparam int CODE_W      = 3;
	localparam int PROD_W      = ACT_W + CODE_W;
	localparam int SUM_W       = 32;
	localparam int BYTE_W      = 8;
	localparam int LOW_BASE    = ACT_W;
	localparam int HIGH_BASE   = ACT_W + PAIRS * BYTE_W;
	localparam int IN_TDATA_W  = ACT_W + 2 * PAIRS * BYTE_W;
	localparam int OUT_TDATA_W = ROWS * SUM_W;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [SUM_W-1:0]  sum_t;

	// one column travelling along the cell chain
	typedef struct packed {
		logic                     valid;
		logic                     last;
		logic signed [ACT_W-1:0]  act;
		logic [ROWS-1:0][CODE_W-1:0] codes;
		logic [ROWS-1:0][SUM_W-1:0]  sums;
	} link_t;

endpackage

`default_nettype wire

>>> src/q3gemv_cell.sv
// One row cell: holds a row accumulator, consumes the front weight code and
// shifts codes and finished sums on to the next cell. Depends on q3gemv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module q3gemv_cell (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    en,
	input  wire q3gemv_pkg::link_t link_in,
	output q3gemv_pkg::link_t      link_out
);
	import q3gemv_pkg::*;

	logic signed [CODE_W-1:0] weight;
	logic signed [PROD_W-1:0] prod;
	sum_t                     acc_q;
	sum_t                     acc_sum;
	logic                     valid_q;
	link_t                    data_q;

	// code minus four: flip the top bit
	assign weight  = {~link_in.codes[0][CODE_W-1], link_in.codes[0][CODE_W-2:0]};
	assign prod    = weight * link_in.act;
	assign acc_sum = acc_q + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= link_in.valid;
			if (link_in.valid) begin
				acc_q <= link_in.last ? '0 : acc_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q.valid <= 1'b0;
			data_q.last  <= link_in.last;
			data_q.act   <= link_in.act;
			data_q.codes <= {code_t'(0), link_in.codes[ROWS-1:1]};
			data_q.sums  <= {acc_sum, link_in.sums[ROWS-1:1]};
		end
	end

	always_comb begin
		link_out       = data_q;
		link_out.valid = valid_q;
	end

	a_cell_clear: assert property (@(posedge clk) disable iff (!arst_n)
		en && link_in.valid && link_in.last |=> acc_q == '0)
		else $error("accumulator not cleared after last column");

	a_cell_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(acc_q) && $stable(valid_q))
		else $error("cell state moved while stalled");

endmodule

`default_nettype wire

>>> src/q3_weight_gemv_eight_rows_unit.sv
// Eight-row GEMV with 3-bit weights and signed 8-bit activations, one column per transaction.
// Top level; depends on q3gemv_pkg and q3gemv_cell.
`timescale 1ns / 1ps
`default_nettype none

// Takes one matrix column per clock with no bubbles while the master side
// does not stall: the column's activation and eight weight codes walk down
// a chain of eight row cells, one cell per enabled cycle, each cell adding
// its product into its own 32-bit wrapping sum.
// On a column with tlast set the eight sums are handed out as one master
// transaction; m_tvalid rises once the column has passed the chain (the
// first cell loads on the accepting edge, seven more cells and the output
// register follow), and the sums restart from zero. A stall on the master
// side freezes the whole chain, so s_tready follows m_tready whenever a result is waiting.

module q3_weight_gemv_eight_rows_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// activation, low_bits_pair0..3, high_bits_pair0..3
	input  wire  [71:0] s_tdata,
	input  wire         s_tlast,
	output logic        m_tvalid,
	input  wire         m_tready,
	// sum_row0 .. sum_row7
	output logic [255:0] m_tdata
);
	import q3gemv_pkg::*;

	logic                    en;
	link_t                   col_in;
	link_t                   links [ROWS+1];
	logic                    out_valid_q;
	logic [OUT_TDATA_W-1:0]  out_q;

	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	always_comb begin
		col_in.valid = s_tvalid;
		col_in.last  = s_tlast;
		col_in.act   = s_tdata[ACT_W-1:0];
		col_in.sums  = '0;
		for (int p = 0; p < PAIRS; p++) begin
			col_in.codes[2*p]   = {s_tdata[HIGH_BASE + p*BYTE_W],
				s_tdata[LOW_BASE + p*BYTE_W +: 2]};
			col_in.codes[2*p+1] = {s_tdata[HIGH_BASE + p*BYTE_W + 1],
				s_tdata[LOW_BASE + p*BYTE_W + 2 +: 2]};
		end
	end

	assign links[0] = col_in;

	for (genvar i = 0; i < ROWS; i++) begin : g_cell
		q3gemv_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.link_in  (links[i]),
			.link_out (links[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= links[ROWS].valid && links[ROWS].last;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= links[ROWS].sums;
		end
	end

	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		en && links[ROWS].valid && links[ROWS].last |=> m_tvalid)
		else $error("finished column did not produce a result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		en && !(links[ROWS].valid && links[ROWS].last) |=> !m_tvalid)
		else $error("result raised without a last column");

endmodule

`default_nettype wire
